// ----- rtl/core/boot_image_stream_cipher_assert.svh -----
// ----------------------------------------------------------------------------
// Boot image stream cipher assertion macros
// Shared concurrent assertion forms for the checker of the boot stream block.
// ----------------------------------------------------------------------------
`ifndef BOOT_IMAGE_STREAM_CIPHER_ASSERT_SVH
`define BOOT_IMAGE_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BISC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BISC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bisc_pkg.sv -----
// ----------------------------------------------------------------------------
// Boot image stream cipher package
// Types, constants and word functions shared by the boot stream block.
// ----------------------------------------------------------------------------
package bisc_pkg;

    localparam int unsigned MAX_IMAGE_BYTES = 262144;
    localparam int unsigned LEN_W           = 19;
    localparam int unsigned OFF_W           = 19;

    localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_IMAGE_BYTES);
    localparam logic [LEN_W-1:0] LEN_RESET     = 19'h00200;
    localparam logic [OFF_W:0]   HEADER_END    = 20'h000C0;
    localparam logic [31:0]      LCG_MUL       = 32'h6177614B;
    localparam logic [31:0]      LCG_MUL2      = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
    localparam logic [31:0]      LCG_ADD2      = LCG_MUL + 32'd1;
    localparam logic [31:0]      OFFSET_BIAS   = 32'h0200_0000;
    localparam logic [31:0]      FIXED_MASK    = 32'h20796220;
    localparam logic [31:0]      SEED_MASK     = 32'h6F646573;
    localparam logic [15:0]      CRC_POLY      = 16'hA1C1;
    localparam logic [15:0]      CRC_START     = 16'h15A0;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REG_SESSION_SEED = 2'd0,
        REG_IMAGE_LENGTH = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_ENC   = 2'd2,
        KIND_SEAL  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] word;
        kind_t       kind;
        logic        last;
        logic        done;
    } res_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic [31:0] key_word(input logic [LEN_W-1:0] len);
        logic [31:0] s;
        logic [31:0] a;
        logic [7:0]  sum;
        logic [31:0] b;
        s   = (32'(len) - 32'h0000_0200) >> 3;
        a   = ((s & 32'h3F80) << 1) | ((s & 32'h4000) << 2) | (s & 32'h7F) | 32'h0038_0000;
        sum = a[15:8] + a[23:16] + a[7:0];
        b   = {sum, 24'h0} | a | 32'h8080_8080;
        return b[9] ? (b ^ SEED_MASK) : (b ^ LCG_MUL);
    endfunction

    function automatic logic [15:0] crc_word(input logic [15:0] crc_in, input logic [31:0] v);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int k = 0; k < 32; k++) begin
            fb  = crc[0] ^ v[k];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [31:0] offset_term(input logic [31:0] off);
        return 32'd0 - (off + OFFSET_BIAS);
    endfunction

endpackage

// ----- rtl/core/bisc_core.sv -----
// ----------------------------------------------------------------------------
// Boot image stream cipher word engine
// Input register, boot state and the single-pass word transform.
// ----------------------------------------------------------------------------
module bisc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                image_valid,
    output logic                image_ready,
    input  logic [31:0]         image_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                room_two,
    output bisc_pkg::push_t     push,
    output bisc_pkg::res_t      first_res,
    output bisc_pkg::res_t      second_res
);
    import bisc_pkg::*;

    logic              img_valid_reg, img_valid_next;
    logic [31:0]       img_word_reg;
    logic [31:0]       seed_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [31:0]       key_reg, key_next;
    logic [15:0]       crc_reg, crc_next;

    logic              consume;
    logic [LEN_W-1:0]  len_eff;
    logic [OFF_W:0]    nxt;
    logic              at_start;
    logic              header;
    logic              final_word;
    logic [31:0]       key_base;
    logic [15:0]       crc_base;
    logic [15:0]       crc_new;
    logic [15:0]       crc_seal;
    logic [31:0]       k1;
    logic [31:0]       k2;
    logic [31:0]       k_seal;
    logic [31:0]       enc_word;
    logic [31:0]       seal_word;
    res_t              main_res;
    res_t              key_res;
    res_t              seal_res;

    assign cfg_ready   = 1'b1;
    assign consume     = img_valid_reg && room_two;
    assign image_ready = !img_valid_reg || consume;

    always_comb
    begin
        len_eff    = (length_reg > MAX_LEN) ? MAX_LEN : length_reg;
        nxt        = {1'b0, offset_reg} + (OFF_W+1)'(4);
        at_start   = (offset_reg == '0);
        header     = ({1'b0, offset_reg} < HEADER_END);
        final_word = (nxt >= HEADER_END) && (nxt >= {1'b0, len_eff});
        key_base   = at_start ? (seed_reg ^ SEED_MASK) : key_reg;
        crc_base   = at_start ? CRC_START : crc_reg;
        crc_new    = crc_word(crc_base, img_word_reg);
        k1         = key_base * LCG_MUL + 32'd1;
        k2         = key_base * LCG_MUL2 + LCG_ADD2;
        k_seal     = header ? k1 : k2;
        crc_seal   = header ? crc_base : crc_new;
        enc_word   = img_word_reg ^ k1 ^ offset_term(32'(offset_reg)) ^ FIXED_MASK;
        seal_word  = {len_eff[15:0], crc_seal} ^ k_seal ^ offset_term(32'(nxt)) ^ FIXED_MASK;

        key_res.word  = key_word(len_eff);
        key_res.kind  = KIND_KEY;
        key_res.last  = 1'b0;
        key_res.done  = 1'b0;

        main_res.word = header ? img_word_reg : enc_word;
        main_res.kind = header ? KIND_CLEAR : KIND_ENC;
        main_res.last = !final_word;
        main_res.done = 1'b0;

        seal_res.word = seal_word;
        seal_res.kind = KIND_SEAL;
        seal_res.last = 1'b1;
        seal_res.done = 1'b1;

        first_res   = at_start ? key_res : main_res;
        second_res  = at_start ? main_res : seal_res;
        push.first  = consume;
        push.second = consume && (at_start || final_word);

        img_valid_next = image_ready ? image_valid : img_valid_reg;
        offset_next    = offset_reg;
        key_next       = key_reg;
        crc_next       = crc_reg;
        if (consume)
        begin
            if (final_word)
            begin
                offset_next = '0;
                key_next    = k_seal;
                crc_next    = CRC_START;
            end
            else
            begin
                offset_next = nxt[OFF_W-1:0];
                key_next    = header ? key_base : k1;
                crc_next    = header ? crc_base : crc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_valid_reg <= 1'b0;
            seed_reg      <= '0;
            length_reg    <= LEN_RESET;
            offset_reg    <= '0;
            key_reg       <= '0;
            crc_reg       <= CRC_START;
        end
        else
        begin
            img_valid_reg <= img_valid_next;
            offset_reg    <= offset_next;
            key_reg       <= key_next;
            crc_reg       <= crc_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SESSION_SEED: seed_reg   <= cfg_data;
                    REG_IMAGE_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                    default:          seed_reg   <= seed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (image_valid && image_ready)
        begin
            img_word_reg <= image_word;
        end
    end

endmodule

// ----- rtl/core/bisc_out_queue.sv -----
// ----------------------------------------------------------------------------
// Boot image stream cipher result queue
// Small ordered buffer; takes one or two results a cycle, sends one on ready.
// ----------------------------------------------------------------------------
module bisc_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  bisc_pkg::push_t     push,
    input  bisc_pkg::res_t      first_res,
    input  bisc_pkg::res_t      second_res,
    output logic                room_two,
    output logic                send_valid,
    input  logic                send_ready,
    output bisc_pkg::res_t      head_res
);
    import bisc_pkg::*;

    res_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    head_reg, head_next;
    logic [QUEUE_AW-1:0]    tail_reg, tail_next;
    logic [QUEUE_AW:0]      count_reg, count_next;
    logic                   pop;
    logic [QUEUE_AW:0]      n_push;

    assign send_valid = (count_reg != '0);
    assign room_two   = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign pop        = send_valid && send_ready;
    assign head_res   = mem[head_reg];

    always_comb
    begin
        n_push     = (QUEUE_AW+1)'(push.first) + (QUEUE_AW+1)'(push.second);
        head_next  = pop ? head_reg + QUEUE_AW'(1) : head_reg;
        tail_next  = tail_reg + n_push[QUEUE_AW-1:0];
        count_next = count_reg + n_push - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[tail_reg] <= first_res;
        end
        if (push.second)
        begin
            mem[tail_reg + QUEUE_AW'(1)] <= second_res;
        end
    end

endmodule

// ----- rtl/core/boot_image_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// Boot image stream cipher
// Turns image words into the transmitted word stream of a serial boot.
// ----------------------------------------------------------------------------
// Image words arrive on the image channel, one request per 32-bit word. Each
// word passes through the input register and the result queue to the send
// channel. The first word of a boot is preceded by the key word, and the
// final word is followed by the sealed checksum word; these enter the queue
// with the word they accompany. Otherwise, with the receiver ready, one word a
// cycle passes in both directions, set by the single transform stage between
// the input register and the four-entry result queue. The configuration
// channel is always ready. Index 0 holds the session seed and index 1 the
// image length; the user must write both while the block is idle; the block
// does not enforce it. Reset clears the offset, the seed and the queue, loads
// the checksum start value and sets the length to 512 bytes. When the
// receiver stalls, the queue fills and the input register holds its word; the
// image channel then drops ready while fewer than two queue entries are free.
// ----------------------------------------------------------------------------
module boot_image_stream_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        image_valid,
    output logic        image_ready,
    input  logic [31:0] image_word,
    output logic        send_valid,
    input  logic        send_ready,
    output logic [31:0] send_word,
    output logic [1:0]  word_kind,
    output logic        run_last,
    output logic        boot_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bisc_pkg::*;

    logic  room_two;
    push_t push;
    res_t  first_res;
    res_t  second_res;
    res_t  head_res;

    bisc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_valid (image_valid),
        .image_ready (image_ready),
        .image_word  (image_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .room_two    (room_two),
        .push        (push),
        .first_res   (first_res),
        .second_res  (second_res)
    );

    bisc_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .first_res  (first_res),
        .second_res (second_res),
        .room_two   (room_two),
        .send_valid (send_valid),
        .send_ready (send_ready),
        .head_res   (head_res)
    );

    assign send_word = head_res.word;
    assign word_kind = head_res.kind;
    assign run_last  = head_res.last;
    assign boot_done = head_res.done;

endmodule

// ----- rtl/core/bisc_checker.sv -----
// ----------------------------------------------------------------------------
// Boot image stream cipher checker
// Port-level assertions on the send channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "boot_image_stream_cipher_assert.svh"

module bisc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        send_valid,
    input  logic        send_ready,
    input  logic [31:0] send_word,
    input  logic [1:0]  word_kind,
    input  logic        run_last,
    input  logic        boot_done
);
    import bisc_pkg::*;

    `BISC_ASSERT_NEXT(a_send_hold, send_valid && !send_ready, send_valid && $stable(send_word) && $stable(word_kind), "stalled send request changed")
    `BISC_ASSERT_NOW(a_done_is_seal, send_valid && boot_done, (word_kind == KIND_SEAL) && run_last, "boot end flagged on a word that is not the sealed checksum")
    `BISC_ASSERT_NOW(a_seal_is_done, send_valid && (word_kind == KIND_SEAL), boot_done && run_last, "sealed checksum word without boot end")
    `BISC_ASSERT_NOW(a_key_not_last, send_valid && (word_kind == KIND_KEY), !run_last && !boot_done, "key word flagged as last")
    `BISC_ASSERT_NEXT(a_key_then_clear, send_valid && send_ready && (word_kind == KIND_KEY), send_valid && (word_kind == KIND_CLEAR), "key word not followed by a clear header word")

endmodule

bind boot_image_stream_cipher bisc_checker u_checker (.*);
